[rtl/core/postfix_index_expression_evaluator_core_assert.svh]
// assertion macros for the postfix index expression evaluator core
// used by the front and back files
`ifndef POSTFIX_INDEX_EXPRESSION_EVALUATOR_CORE_ASSERT_SVH
`define POSTFIX_INDEX_EXPRESSION_EVALUATOR_CORE_ASSERT_SVH

// implication checked on every clock edge out of reset
`define PIE_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// implication with the consequent checked in the next cycle
`define PIE_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/pie_pkg.sv]
// shared types and codes for the postfix index expression evaluator
// no dependencies
`timescale 1ns / 1ps

package pie_pkg;

    typedef enum logic [2:0] {
        OP_LIT    = 3'd0,
        OP_ITER   = 3'd1,
        OP_OFFSET = 3'd2,
        OP_MULT   = 3'd3,
        OP_ADD    = 3'd4,
        OP_SUB    = 3'd5,
        OP_MUL    = 3'd6,
        OP_DIV    = 3'd7
    } op_t;

    typedef enum logic [2:0] {
        ERR_OK      = 3'd0,
        ERR_UNDER   = 3'd1,
        ERR_OVER    = 3'd2,
        ERR_DIVZERO = 3'd3,
        ERR_DEPTH   = 3'd4
    } err_t;

    // classified term handed from front to back
    typedef struct packed {
        op_t         op;
        logic [63:0] lit;
        logic [63:0] itv;
        logic        last;
    } term_t;

endpackage

[rtl/core/postfix_index_expression_evaluator_core.sv]
// Postfix index expression evaluator: one term per request on s_, one result per
// last term on m_. In the back end a push term passes the read, calc, write and
// bottom states, and an add or sub reads a second operand first; multiply terms
// use one 32 by 32 multiplier three times; a divide uses the bit-serial 64-bit
// divider; a stack error goes straight to the bottom state; a last term adds an
// output state to hand out the result. A two-entry queue lets the input take terms
// while the back end works or the result waits. depends on pie_pkg, pie_front, pie_back
`timescale 1ns / 1ps

module postfix_index_expression_evaluator_core #(
    parameter int STACK_DEPTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_operation,
    input  logic [63:0] s_literal,
    input  logic [63:0] s_iterator_value,
    input  logic        s_last_term,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_value,
    output logic [2:0]  m_error_code
);
    import pie_pkg::*;

    term_t in_term, q_term;
    logic  q_valid, q_ready;

    // pack the request
    always_comb begin
        in_term.op   = op_t'(s_operation);
        in_term.lit  = s_literal;
        in_term.itv  = s_iterator_value;
        in_term.last = s_last_term;
    end

    pie_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_valid),
        .in_ready (s_ready),
        .in_term  (in_term),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_term   (q_term)
    );

    pie_back #(.STACK_DEPTH(STACK_DEPTH)) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_valid      (q_valid),
        .q_ready      (q_ready),
        .q_term       (q_term),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_value      (m_value),
        .m_error_code (m_error_code)
    );
endmodule

[rtl/core/pie_ram.sv]
// generic ram with one write port and one registered read port
// no dependencies
`timescale 1ns / 1ps

module pie_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end
endmodule

[rtl/core/pie_front.sv]
// front end: accepts terms into a two entry queue
// depends on pie_pkg
`timescale 1ns / 1ps

module pie_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  pie_pkg::term_t in_term,
    output logic          q_valid,
    input  logic          q_ready,
    output pie_pkg::term_t q_term
);
    import pie_pkg::*;

    term_t      ent_reg [2];
    logic [1:0] cnt_reg, cnt_next;
    logic       rd_reg, rd_next, wr_reg, wr_next;
    logic       push, pop;

    assign in_ready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_term   = ent_reg[rd_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    // pointer and count update
    always_comb begin
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
        wr_next  = wr_reg ^ push;
        rd_next  = rd_reg ^ pop;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            rd_reg  <= rd_next;
            wr_reg  <= wr_next;
        end
    end

    // queue storage
    always_ff @(posedge aclk) begin
        if (push) begin
            ent_reg[wr_reg] <= in_term;
        end
    end

    `include "postfix_index_expression_evaluator_core_assert.svh"
    `PIE_ASSERT_IMP(a_no_overfill, aclk, aresetn, 1'b1, cnt_reg <= 2'd2, "queue count")
    `PIE_ASSERT_NEXT(a_hold, aclk, aresetn, push && !pop, cnt_reg != 2'd0, "push lost")
    `PIE_ASSERT_IMP(a_ptr, aclk, aresetn, cnt_reg == 2'd0 || cnt_reg == 2'd2, rd_reg == wr_reg, "ptr")
endmodule

[rtl/core/pie_back.sv]
// back end: stack sequencer, multiplier and iterative divider
// depends on pie_pkg and pie_ram
`timescale 1ns / 1ps

module pie_back #(
    parameter int STACK_DEPTH = 16
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           q_valid,
    output logic           q_ready,
    input  pie_pkg::term_t q_term,
    output logic           m_valid,
    input  logic           m_ready,
    output logic [63:0]    m_value,
    output logic [2:0]     m_error_code
);
    import pie_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int DW = $clog2(STACK_DEPTH + 1);
    localparam logic [DW-1:0] FULL = DW'(STACK_DEPTH);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b0_0000_0001,
        S_RD1   = 9'b0_0000_0010,
        S_RD2   = 9'b0_0000_0100,
        S_CALC  = 9'b0_0000_1000,
        S_DIV   = 9'b0_0001_0000,
        S_WRITE = 9'b0_0010_0000,
        S_BOT   = 9'b0_0100_0000,
        S_OUT   = 9'b0_1000_0000,
        S_MUL   = 9'b1_0000_0000
    } state_t;

    state_t         state_reg, state_next;
    term_t          t_reg, t_next;
    logic [DW-1:0]  depth_reg, depth_next;
    logic [2:0]     err_reg, err_next;
    logic [63:0]    a_reg, a_next, b_reg, b_next;
    logic [63:0]    r_reg, r_next;
    logic [63:0]    rem_reg, rem_next;
    logic [6:0]     cnt_reg, cnt_next;
    logic [AW-1:0]  waddr_reg, waddr_next;
    logic           ov_reg, ov_next;
    logic [63:0]    ov_val_reg, ov_val_next;
    logic [2:0]     ov_err_reg, ov_err_next;

    logic           we;
    logic [AW-1:0]  raddr;
    logic [63:0]    rdata;
    logic [64:0]    trial;
    logic [31:0]    mul_x, mul_y;
    logic [63:0]    prod;

    pie_ram #(.WIDTH(64), .DEPTH(STACK_DEPTH)) u_stack (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr_reg),
        .wdata (r_reg),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign q_ready      = (state_reg == S_IDLE);
    assign m_valid      = ov_reg;
    assign m_value      = ov_val_reg;
    assign m_error_code = ov_err_reg;
    assign we           = (state_reg == S_WRITE);
    assign trial        = {rem_reg, a_reg[63]} - {1'b0, t_reg.lit};

    // 32 by 32 partial products: low by low, low by high, high by low
    always_comb begin
        mul_x = (cnt_reg == 7'd2) ? a_reg[63:32] : a_reg[31:0];
        mul_y = (cnt_reg == 7'd1) ? b_reg[63:32] : b_reg[31:0];
    end
    assign prod = mul_x * mul_y;

    // stack read address by state
    always_comb begin
        raddr = '0;
        if (state_reg == S_RD1) begin
            raddr = AW'(depth_reg - DW'(1));
        end else if (state_reg == S_RD2) begin
            raddr = AW'(depth_reg - DW'(2));
        end
    end

    // term sequencer
    always_comb begin
        state_next  = state_reg;
        t_next      = t_reg;
        depth_next  = depth_reg;
        err_next    = err_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        r_next      = r_reg;
        rem_next    = rem_reg;
        cnt_next    = cnt_reg;
        waddr_next  = waddr_reg;
        ov_next     = ov_reg;
        ov_val_next = ov_val_reg;
        ov_err_next = ov_err_reg;
        if (ov_reg && m_ready) begin
            ov_next = 1'b0;
        end
        case (state_reg)
            S_IDLE: begin
                if (q_valid) begin
                    t_next     = q_term;
                    state_next = S_RD1;
                end
            end
            S_RD1: begin
                // classify and check stack bounds
                state_next = S_BOT;
                case (t_reg.op)
                    OP_LIT, OP_ITER, OP_OFFSET, OP_MULT: begin
                        if (depth_reg >= FULL) begin
                            if (err_reg == ERR_OK) err_next = ERR_OVER;
                        end else begin
                            state_next = S_CALC;
                        end
                    end
                    OP_ADD, OP_SUB, OP_MUL: begin
                        if (depth_reg < DW'(2)) begin
                            if (err_reg == ERR_OK) err_next = ERR_UNDER;
                        end else begin
                            state_next = S_RD2;
                        end
                    end
                    default: begin
                        if (depth_reg < DW'(1)) begin
                            if (err_reg == ERR_OK) err_next = ERR_UNDER;
                        end else if (t_reg.lit == 64'd0) begin
                            if (err_reg == ERR_OK) err_next = ERR_DIVZERO;
                        end else begin
                            state_next = S_RD2;
                        end
                    end
                endcase
            end
            S_RD2: begin
                // rdata holds top of stack
                b_next = rdata;
                if (t_reg.op == OP_DIV) begin
                    a_next     = rdata;
                    rem_next   = '0;
                    cnt_next   = 7'd64;
                    waddr_next = AW'(depth_reg - DW'(1));
                    state_next = S_DIV;
                end else begin
                    state_next = S_CALC;
                end
            end
            S_CALC: begin
                // rdata holds second operand for binary terms
                case (t_reg.op)
                    OP_LIT:    r_next = t_reg.lit;
                    OP_ITER:   r_next = t_reg.itv;
                    OP_OFFSET: r_next = t_reg.lit + t_reg.itv;
                    OP_MULT: begin
                        a_next = t_reg.lit;
                        b_next = t_reg.itv;
                    end
                    OP_ADD:    r_next = rdata + b_reg;
                    OP_SUB:    r_next = rdata - b_reg;
                    OP_MUL:    a_next = rdata;
                    default:   r_next = rdata;
                endcase
                if (t_reg.op == OP_ADD || t_reg.op == OP_SUB || t_reg.op == OP_MUL) begin
                    waddr_next = AW'(depth_reg - DW'(2));
                    depth_next = depth_reg - DW'(1);
                end else begin
                    waddr_next = AW'(depth_reg);
                    depth_next = depth_reg + DW'(1);
                end
                if (t_reg.op == OP_MULT || t_reg.op == OP_MUL) begin
                    cnt_next   = 7'd0;
                    state_next = S_MUL;
                end else begin
                    state_next = S_WRITE;
                end
            end
            S_MUL: begin
                // low 64 bits of the product from three partial products
                if (cnt_reg == 7'd0) begin
                    r_next = prod;
                end else begin
                    r_next = r_reg + {prod[31:0], 32'd0};
                end
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == 7'd2) begin
                    state_next = S_WRITE;
                end
            end
            S_DIV: begin
                // restoring division, one quotient bit a cycle
                a_next = {a_reg[62:0], ~trial[64]};
                if (!trial[64]) begin
                    rem_next = trial[63:0];
                end else begin
                    rem_next = {rem_reg[62:0], a_reg[63]};
                end
                cnt_next = cnt_reg - 7'd1;
                if (cnt_reg == 7'd1) begin
                    r_next     = {a_reg[62:0], ~trial[64]};
                    state_next = S_WRITE;
                end
            end
            S_WRITE: begin
                state_next = S_BOT;
            end
            S_BOT: begin
                // read bottom for the result on a last term
                if (t_reg.last) begin
                    state_next = S_OUT;
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_OUT: begin
                if (!ov_reg || m_ready) begin
                    ov_next     = 1'b1;
                    ov_val_next = (depth_reg >= DW'(1)) ? rdata : 64'd0;
                    ov_err_next = (err_reg == ERR_OK && depth_reg != DW'(1))
                                  ? ERR_DEPTH : err_reg;
                    depth_next  = '0;
                    err_next    = ERR_OK;
                    state_next  = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            depth_reg <= '0;
            err_reg   <= ERR_OK;
            ov_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            depth_reg <= depth_next;
            err_reg   <= err_next;
            ov_reg    <= ov_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        t_reg      <= t_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        r_reg      <= r_next;
        rem_reg    <= rem_next;
        cnt_reg    <= cnt_next;
        waddr_reg  <= waddr_next;
        ov_val_reg <= ov_val_next;
        ov_err_reg <= ov_err_next;
    end

    `include "postfix_index_expression_evaluator_core_assert.svh"
    `PIE_ASSERT_IMP(a_depth_bound, aclk, aresetn, 1'b1, depth_reg <= FULL, "depth over")
    `PIE_ASSERT_IMP(a_err_range, aclk, aresetn, ov_reg, ov_err_reg <= ERR_DEPTH, "bad code")
    `PIE_ASSERT_NEXT(a_out_clear, aclk, aresetn, state_reg == S_OUT && state_next == S_IDLE, depth_reg == '0 && err_reg == ERR_OK, "no clear")
endmodule

[verif/tb.sv]
// self-checking bench for postfix_index_expression_evaluator_core: postfix term requests
// in, expression results checked against an in-bench stack evaluator; depends on pie_pkg
`timescale 1ns / 1ps

module tb;
    import pie_pkg::*;

    localparam int DEPTH = 16;
    localparam int CYCLE_LIMIT = 1500000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [2:0]  s_operation = 3'd0;
    logic [63:0] s_literal = 64'd0;
    logic [63:0] s_iterator_value = 64'd0;
    logic        s_last_term = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [63:0] m_value;
    logic [2:0]  m_error_code;

    postfix_index_expression_evaluator_core #(.STACK_DEPTH(DEPTH)) uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_operation(s_operation),
        .s_literal(s_literal), .s_iterator_value(s_iterator_value),
        .s_last_term(s_last_term),
        .m_valid(m_valid), .m_ready(m_ready), .m_value(m_value),
        .m_error_code(m_error_code)
    );

    // clock
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // evaluator state mirrored in the bench
    logic [63:0] eval_stack [DEPTH];
    int          eval_depth;
    err_t        eval_err;

    typedef struct {
        logic [63:0] value;
        err_t        code;
    } outcome_t;
    outcome_t expected_results[$];

    int errors = 0;
    int cycles = 0;
    int ready_wait = 0;
    bit no_stall = 1'b0;

    function automatic void note_err(err_t e);
        if (eval_err == ERR_OK) eval_err = e;
    endfunction

    function automatic void push_operand(logic [63:0] v);
        if (eval_depth >= DEPTH) note_err(ERR_OVER);
        else begin
            eval_stack[eval_depth] = v;
            eval_depth++;
        end
    endfunction

    // apply one term, queue a result on the last term
    function automatic void evaluate_term(op_t op, logic [63:0] lit, logic [63:0] itv,
                                          bit last);
        logic [63:0] a, b;
        outcome_t r;
        case (op)
            OP_LIT:    push_operand(lit);
            OP_ITER:   push_operand(itv);
            OP_OFFSET: push_operand(lit + itv);
            OP_MULT:   push_operand(lit * itv);
            OP_ADD, OP_SUB, OP_MUL: begin
                if (eval_depth < 2) note_err(ERR_UNDER);
                else begin
                    b = eval_stack[eval_depth-1];
                    a = eval_stack[eval_depth-2];
                    eval_stack[eval_depth-2] = (op == OP_ADD) ? a + b :
                                               (op == OP_SUB) ? a - b : a * b;
                    eval_depth--;
                end
            end
            default: begin
                if (eval_depth < 1) note_err(ERR_UNDER);
                else if (lit == 64'd0) note_err(ERR_DIVZERO);
                else eval_stack[eval_depth-1] = eval_stack[eval_depth-1] / lit;
            end
        endcase
        if (last) begin
            r.code = eval_err;
            if (r.code == ERR_OK && eval_depth != 1) r.code = ERR_DEPTH;
            r.value = (eval_depth >= 1) ? eval_stack[0] : 64'd0;
            expected_results.insert(expected_results.size(), r);
            eval_depth = 0;
            eval_err = ERR_OK;
        end
    endfunction

    // send one term request with a random gap in front
    task automatic send_term(op_t op, logic [63:0] lit, logic [63:0] itv, bit last);
        int gap;
        gap = no_stall ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_operation <= op;
        s_literal <= lit;
        s_iterator_value <= itv;
        s_last_term <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        evaluate_term(op, lit, itv, last);
    endtask

    function automatic logic [63:0] rand64();
        case ($urandom_range(0, 5))
            0: return 64'd0;
            1: return '1;
            2: return 64'd1 << $urandom_range(0, 63);
            3: return 64'($urandom_range(0, 20));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // result side: random wait per result, check against the oldest expectation
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result value=%h error_code=%0d", m_value, m_error_code);
                    errors++;
                end else begin
                    if (m_value !== expected_results[0].value) begin
                        $error("value expected %h actual %h", expected_results[0].value,
                               m_value);
                        errors++;
                    end
                    if (m_error_code !== expected_results[0].code) begin
                        $error("error_code expected %0d actual %0d",
                               expected_results[0].code, m_error_code);
                        errors++;
                    end
                    void'(expected_results.pop_front());
                end
                ready_wait = no_stall ? 0 : $urandom_range(0, 8);
            end else if (m_valid && ready_wait > 0) begin
                ready_wait--;
            end
            m_ready <= (ready_wait == 0);
        end
    end

    // run limit
    always @(posedge aclk) begin
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // directed: every operation, field extremes, each error kind
    task automatic test_directed();
        send_term(OP_LIT, '1, 64'd0, 0);
        send_term(OP_ITER, 64'd0, '1, 0);
        send_term(OP_ADD, 64'd0, 64'd0, 0);
        send_term(OP_OFFSET, '1, 64'd2, 0);
        send_term(OP_SUB, 64'd0, 64'd0, 0);
        send_term(OP_MULT, 64'h8000_0000_0000_0001, '1, 0);
        send_term(OP_MUL, 64'd0, 64'd0, 0);
        send_term(OP_DIV, 64'd3, 64'd0, 1);
        // underflow on empty binary and divide
        send_term(OP_ADD, 64'd0, 64'd0, 1);
        send_term(OP_DIV, 64'd5, 64'd0, 1);
        // divide by zero, then sticky over later underflow
        send_term(OP_LIT, 64'd9, 64'd0, 0);
        send_term(OP_DIV, 64'd0, 64'd0, 0);
        send_term(OP_SUB, 64'd0, 64'd0, 1);
        // bad final depth
        send_term(OP_LIT, 64'd1, 64'd0, 0);
        send_term(OP_LIT, 64'd2, 64'd0, 1);
        // overflow
        for (int i = 0; i <= DEPTH; i++) send_term(OP_ITER, 64'd0, 64'(i), i == DEPTH);
    endtask

    // random: mostly well-formed expressions, some noise
    task automatic test_random(int n_terms);
        int sent, d, len;
        bit closed;
        sent = 0;
        while (sent < n_terms) begin
            no_stall = ($urandom_range(0, 9) == 0);
            if ($urandom_range(0, 4) == 0) begin
                len = $urandom_range(1, 20);
                for (int i = 0; i < len; i++)
                    send_term(op_t'($urandom_range(0, 7)), rand64(), rand64(), i == len - 1);
                sent += len;
            end else begin
                d = 0;
                len = $urandom_range(1, 14);
                for (int i = 0; i < len; i++) begin
                    if (d >= 2 && ($urandom_range(0, 2) == 0 || d >= DEPTH)) begin
                        send_term(op_t'($urandom_range(OP_ADD, OP_MUL)), 64'd0, 64'd0, 0);
                        d--;
                    end else if (d >= 1 && $urandom_range(0, 9) == 0) begin
                        send_term(OP_DIV, rand64() | 64'd1, 64'd0, 0);
                    end else begin
                        send_term(op_t'($urandom_range(OP_LIT, OP_MULT)), rand64(), rand64(),
                                  0);
                        d++;
                    end
                    sent++;
                end
                closed = 1'b0;
                while (d > 1) begin
                    closed = (d == 2);
                    send_term(op_t'($urandom_range(OP_ADD, OP_MUL)), 64'd0, 64'd0, d == 2);
                    d--;
                    sent++;
                end
                // close the expression when the reduction did not
                if (!closed) begin
                    send_term(OP_DIV, rand64(), 64'd0, 1);
                    sent++;
                end
            end
        end
        no_stall = 1'b0;
    endtask

    initial begin
        eval_depth = 0;
        eval_err = ERR_OK;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random(1520);
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (errors == 0 && expected_results.size() == 0) $display("ALL CHECKS PASSED");
        else $display("CHECKS FAILED");
        $finish;
    end
endmodule
